// ===== sv/kera_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kera_pkg: shared types and constants of the key-event report aggregator
// Field widths, register indexes, reset values and the queue entry format.
// ----------------------------------------------------------------------------
package kera_pkg;

	// Fixed field widths
	localparam int CODE_W   = 16;
	localparam int OUT_W    = 16;
	localparam int VALUE_W  = 2;
	localparam int MAXR_W   = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Key slots that own a code register
	localparam int KEY_SLOTS = 5;
	localparam int KEY_IDX_W = 3;

	// Command queue between front and back
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_A       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_B       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_C       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_D       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_E       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REPORTS = 3'd5;

	// Input mode codes
	localparam logic MODE_EVENT = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	// Key value code for a release; everything else is a press
	localparam logic [VALUE_W-1:0] VALUE_RELEASE = 2'd0;

	typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] key_code_arr_t;

	// Slot 0 sits in the low bits
	localparam key_code_arr_t KEY_CODE_RESET = {
		16'h001c, 16'h0067, 16'h0069, 16'h006a, 16'h006c
	};
	localparam logic [MAXR_W-1:0] MAX_REPORTS_RESET = 8'd30;

	// One classified transaction in the command queue
	typedef struct packed {
		logic                 is_tick;
		logic [KEY_IDX_W-1:0] key;
		logic                 is_press;
	} cmd_t;

endpackage

// ===== sv/kera_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kera_ifs: valid/ready channels of the key-event report aggregator
// Input item channel and report record channel.
// ----------------------------------------------------------------------------
interface kera_item_if import kera_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [CODE_W-1:0]  key_code;
	logic [VALUE_W-1:0] key_value;

	modport source (output valid, mode, key_code, key_value, input ready);
	modport sink   (input valid, mode, key_code, key_value, output ready);
endinterface

interface kera_rec_if import kera_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CODE_W-1:0] report_key;
	logic [OUT_W-1:0] release_total;
	logic [OUT_W-1:0] press_total;
	logic [OUT_W-1:0] held_ticks;
	logic             last;
	logic             session_over;

	modport source (output valid, report_key, release_total, press_total, held_ticks,
		last, session_over, input ready);
	modport sink   (input valid, report_key, release_total, press_total, held_ticks,
		last, session_over, output ready);
endinterface

// ===== sv/kera_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kera_front: configuration registers and input classification
// Holds the key codes and report limit, matches key events to a slot and
// pushes ticks and matched events into the command queue.
// ----------------------------------------------------------------------------
module kera_front import kera_pkg::*; #(
	parameter int NUM_KEYS = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	kera_item_if.sink             item,
	input  logic                  full,
	output logic                  push,
	output cmd_t                  push_cmd,
	output key_code_arr_t         key_codes,
	output logic [MAXR_W-1:0]     max_reports
);

	key_code_arr_t       key_codes_q;
	logic [MAXR_W-1:0]   max_reports_q;
	logic                hit;
	logic [KEY_IDX_W-1:0] hit_idx;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_codes_q   <= KEY_CODE_RESET;
			max_reports_q <= MAX_REPORTS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D, REG_KEY_E: begin
					key_codes_q[cfg_index] <= cfg_data[CODE_W-1:0];
				end
				REG_MAX_REPORTS: begin
					max_reports_q <= cfg_data[MAXR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Lowest matching slot wins: scan downward so the last hit is the lowest
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (key_codes_q[i] == item.key_code) begin
				hit     = 1'b1;
				hit_idx = KEY_IDX_W'(i);
			end
		end
	end

	// Unmatched key events are taken and dropped
	assign item.ready        = !full;
	assign push              = item.valid && !full && ((item.mode == MODE_TICK) || hit);
	assign push_cmd.is_tick  = (item.mode == MODE_TICK);
	assign push_cmd.key      = hit_idx;
	assign push_cmd.is_press = (item.key_value != VALUE_RELEASE);

	assign key_codes   = key_codes_q;
	assign max_reports = max_reports_q;

endmodule

// ===== sv/kera_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kera_fifo: command queue between front and back
// A small first-in first-out buffer of classified transactions.
// ----------------------------------------------------------------------------
module kera_fifo import kera_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_PTR_W:0]   count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign full  = (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign empty = (count_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (CMD_PTR_W+1)'(CMD_DEPTH))
		else $error("command queue fill level out of range");

endmodule

// ===== sv/kera_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kera_back: counters, report walk and record output register
// Applies key events to the per-key counters; on a tick while armed it walks
// the keys, emits one record per key with a nonzero counter, then updates.
// ----------------------------------------------------------------------------
module kera_back import kera_pkg::*; #(
	parameter int NUM_KEYS   = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  cmd_t              head,
	output logic              pop,
	input  key_code_arr_t     key_codes,
	input  logic [MAXR_W-1:0] max_reports,
	kera_rec_if.source        rec
);

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_WALK   = 2'd1;
	localparam logic [1:0] S_UPDATE = 2'd2;

	logic [COUNT_BITS-1:0] rel_q  [NUM_KEYS];
	logic [COUNT_BITS-1:0] prs_q  [NUM_KEYS];
	logic [COUNT_BITS-1:0] hold_q [NUM_KEYS];
	logic                  armed_q;
	logic [MAXR_W-1:0]     reports_q;
	logic [1:0]            state_q;
	logic [KW-1:0]         idx_q;
	logic [NUM_KEYS-1:0]   nz_q;
	logic [NUM_KEYS-1:0]   live_q;
	logic                  keep_q;

	logic                  out_valid_q;
	logic [CODE_W-1:0]     report_key_q;
	logic [OUT_W-1:0]      release_total_q;
	logic [OUT_W-1:0]      press_total_q;
	logic [OUT_W-1:0]      held_ticks_q;
	logic                  last_q;
	logic                  session_over_q;

	logic [NUM_KEYS-1:0]   nz;
	logic [NUM_KEYS-1:0]   live;
	logic [MAXR_W:0]       next_reports;
	logic                  keep_now;
	logic                  out_free;
	logic                  emit;
	logic                  advance;
	logic                  idx_end;
	logic [NUM_KEYS:0]     above;
	logic                  is_last;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_BITS-1:0] v);
		logic [COUNT_BITS+OUT_W-1:0] w;
		w = {{OUT_W{1'b0}}, v};
		return w[OUT_W-1:0];
	endfunction

	// Per-key activity flags
	always_comb begin
		for (int i = 0; i < NUM_KEYS; i++) begin
			nz[i]   = (rel_q[i] != '0) || (prs_q[i] != '0) || (hold_q[i] != '0);
			live[i] = (prs_q[i] != '0) || (hold_q[i] != '0);
		end
	end

	// Session decision for a tick taken now
	assign next_reports = {1'b0, reports_q} + 1'b1;
	assign keep_now     = (|nz) && (|live) && (next_reports <= {1'b0, max_reports});

	// Walk control
	assign pop      = (state_q == S_IDLE) && !empty;
	assign out_free = !out_valid_q || rec.ready;
	assign emit     = (state_q == S_WALK) && nz_q[idx_q] && out_free;
	assign advance  = (state_q == S_WALK) && (!nz_q[idx_q] || out_free);
	assign idx_end  = (idx_q == KW'(NUM_KEYS - 1));
	assign above    = {1'b0, nz_q} >> idx_q;
	assign is_last  = (above[NUM_KEYS:1] == '0);

	// Sequencer, session state and report bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			armed_q   <= 1'b0;
			reports_q <= '0;
			idx_q     <= '0;
			nz_q      <= '0;
			live_q    <= '0;
			keep_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop && !head.is_tick) begin
						armed_q <= 1'b1;
					end else if (pop && armed_q) begin
						if (keep_now) begin
							reports_q <= next_reports[MAXR_W-1:0];
						end else begin
							armed_q   <= 1'b0;
							reports_q <= '0;
						end
						if (|nz) begin
							state_q <= S_WALK;
							idx_q   <= '0;
							nz_q    <= nz;
							live_q  <= live;
							keep_q  <= keep_now;
						end
					end
				end
				S_WALK: begin
					if (advance) begin
						if (idx_end) begin
							state_q <= S_UPDATE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_UPDATE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-key counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				rel_q[i]  <= '0;
				prs_q[i]  <= '0;
				hold_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				if (pop && !head.is_tick && (head.key == KEY_IDX_W'(i))) begin
					if (head.is_press) begin
						prs_q[i] <= sat_inc(prs_q[i]);
					end else begin
						rel_q[i] <= sat_inc(rel_q[i]);
					end
					hold_q[i] <= '0;
				end else if (state_q == S_UPDATE) begin
					hold_q[i] <= (live_q[i] && keep_q) ? sat_inc(hold_q[i]) : '0;
					rel_q[i]  <= '0;
					prs_q[i]  <= '0;
				end
			end
		end
	end

	// Record output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rec.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			report_key_q    <= key_codes[KEY_IDX_W'(idx_q)];
			release_total_q <= to_out(rel_q[idx_q]);
			press_total_q   <= to_out(prs_q[idx_q]);
			held_ticks_q    <= to_out(hold_q[idx_q]);
			last_q          <= is_last;
			session_over_q  <= !keep_q;
		end
	end

	assign rec.valid         = out_valid_q;
	assign rec.report_key    = report_key_q;
	assign rec.release_total = release_total_q;
	assign rec.press_total   = press_total_q;
	assign rec.held_ticks    = held_ticks_q;
	assign rec.last          = last_q;
	assign rec.session_over  = session_over_q;

	a_update_returns: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPDATE |=> state_q == S_IDLE)
		else $error("update step did not return to idle");

	a_disarmed_count: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> reports_q == '0)
		else $error("report count nonzero while disarmed");

	a_walk_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> nz_q != '0)
		else $error("key walk started with nothing to report");

	a_walk_starts_low: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) ##1 (state_q == S_WALK) |-> idx_q == '0)
		else $error("key walk did not start at the first key");

endmodule

// ===== sv/key_event_report_aggregator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_report_aggregator: per-key event counting with periodic reports
// Channel item carries key events (mode 0) and report ticks (mode 1); channel
// rec carries one record per reported key, last set on the final record of a
// tick. The user must write registers through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce this. An accepted transaction
// enters a four-entry command queue; the back end takes one queued command per
// cycle when idle. A tick while armed decides the session in the idle state,
// then the walk visits each key in turn and the update state updates the
// counters; the first record passes through the walk state and the record
// output register before it shows on rec. A tick while disarmed, or with
// nothing to report, starts no walk.
// The walk pace is set by the single record output register.
// Reset clears all counters, disarms reporting and restores the default key
// codes and report limit. While rec is stalled the walk holds on a key with a
// record to emit; once the queue is full item.ready drops until the back end drains it.
// ----------------------------------------------------------------------------
module key_event_report_aggregator import kera_pkg::*; #(
	parameter int NUM_KEYS   = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	kera_item_if.sink             item,
	kera_rec_if.source            rec
);

	logic              push;
	cmd_t              push_cmd;
	logic              pop;
	cmd_t              head;
	logic              full;
	logic              empty;
	key_code_arr_t     key_codes;
	logic [MAXR_W-1:0] max_reports;

	kera_front #(
		.NUM_KEYS (NUM_KEYS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item        (item),
		.full        (full),
		.push        (push),
		.push_cmd    (push_cmd),
		.key_codes   (key_codes),
		.max_reports (max_reports)
	);

	kera_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	kera_back #(
		.NUM_KEYS   (NUM_KEYS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.key_codes   (key_codes),
		.max_reports (max_reports),
		.rec         (rec)
	);

endmodule

// ===== verif/kera_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kera_checker: record predictor and scoreboard for the key-event aggregator
// Watches register writes and both channels. Every accepted item updates a
// private copy of the per-key counters and session state; ticks push the
// records they should produce. Every accepted record is compared field by
// field against the oldest pending one. Mismatch count and the number of
// records still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module kera_checker import kera_pkg::*; #(
	parameter int NUM_KEYS = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	kera_item_if                  item,
	kera_rec_if                   rec,
	output int                    errors,
	output int                    outstanding
);

	typedef struct packed {
		logic [CODE_W-1:0] key;
		logic [OUT_W-1:0]  rel;
		logic [OUT_W-1:0]  prs;
		logic [OUT_W-1:0]  held;
		logic              last;
		logic              over;
	} key_record_t;

	// Predicted configuration and counter state
	key_code_arr_t     codes;
	logic [MAXR_W-1:0] max_rep;
	logic [OUT_W-1:0]  rel_cnt  [KEY_SLOTS];
	logic [OUT_W-1:0]  prs_cnt  [KEY_SLOTS];
	logic [OUT_W-1:0]  hold_cnt [KEY_SLOTS];
	logic              armed;
	int                session_reports;

	key_record_t due_records[$];
	int          err_count;
	int          records_seen;

	function automatic logic [OUT_W-1:0] bump(input logic [OUT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: record %0d %s: got %0h, expected %0h",
			$time, records_seen, what, got, want);
		err_count++;
	endtask

	// Apply one accepted transaction to the model; ticks queue their records
	task automatic aggregate_item(input logic m, input logic [CODE_W-1:0] c,
		input logic [VALUE_W-1:0] v);
		key_record_t burst[$];
		key_record_t r;
		logic        keep;
		logic        found;
		keep  = 1'b0;
		found = 1'b0;
		if (m == MODE_EVENT) begin
			// lowest matching slot wins
			for (int i = 0; i < NUM_KEYS; i++) begin
				if (!found && codes[i] == c) begin
					found = 1'b1;
					if (v == VALUE_RELEASE)
						rel_cnt[i] = bump(rel_cnt[i]);
					else
						prs_cnt[i] = bump(prs_cnt[i]);
					hold_cnt[i] = '0;
					armed = 1'b1;
				end
			end
		end else if (armed) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				if ((rel_cnt[i] | prs_cnt[i] | hold_cnt[i]) != '0) begin
					r.key  = codes[i];
					r.rel  = rel_cnt[i];
					r.prs  = prs_cnt[i];
					r.held = hold_cnt[i];
					r.last = 1'b0;
					r.over = 1'b0;
					burst.push_back(r);
					if ((prs_cnt[i] | hold_cnt[i]) != '0)
						keep = 1'b1;
				end
			end
			if (burst.size() > 0) begin
				// session limit check, then advance or clear holds
				if (session_reports + 1 > int'(max_rep))
					keep = 1'b0;
				else
					session_reports++;
				for (int i = 0; i < NUM_KEYS; i++) begin
					if ((prs_cnt[i] | hold_cnt[i]) != '0 && keep)
						hold_cnt[i] = bump(hold_cnt[i]);
					else
						hold_cnt[i] = '0;
					rel_cnt[i] = '0;
					prs_cnt[i] = '0;
				end
			end
			if (!keep) begin
				armed = 1'b0;
				session_reports = 0;
			end
			foreach (burst[k]) begin
				burst[k].over = !keep;
				burst[k].last = (k == burst.size() - 1);
				due_records.push_back(burst[k]);
			end
		end
	endtask

	task automatic compare_record(input key_record_t got);
		key_record_t want;
		if (due_records.size() == 0) begin
			report_mismatch("arrived with nothing pending, report_key", got.key, 0);
		end else begin
			want = due_records.pop_front();
			if (got.key !== want.key)   report_mismatch("report_key", got.key, want.key);
			if (got.rel !== want.rel)   report_mismatch("release_total", got.rel, want.rel);
			if (got.prs !== want.prs)   report_mismatch("press_total", got.prs, want.prs);
			if (got.held !== want.held) report_mismatch("held_ticks", got.held, want.held);
			if (got.last !== want.last) report_mismatch("last", got.last, want.last);
			if (got.over !== want.over)
				report_mismatch("session_over", got.over, want.over);
		end
		records_seen++;
	endtask

	// Records are checked before a new tick is predicted at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes   = KEY_CODE_RESET;
			max_rep = MAX_REPORTS_RESET;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				rel_cnt[i]  = '0;
				prs_cnt[i]  = '0;
				hold_cnt[i] = '0;
			end
			armed           = 1'b0;
			session_reports = 0;
			due_records.delete();
			err_count    = 0;
			records_seen = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index <= REG_KEY_E)
					codes[cfg_index] = cfg_data[CODE_W-1:0];
				else if (cfg_index == REG_MAX_REPORTS)
					max_rep = cfg_data[MAXR_W-1:0];
			end
			if (rec.valid && rec.ready)
				compare_record({rec.report_key, rec.release_total, rec.press_total,
					rec.held_ticks, rec.last, rec.session_over});
			if (item.valid && item.ready)
				aggregate_item(item.mode, item.key_code, item.key_value);
			errors      <= err_count;
			outstanding <= due_records.size();
		end
	end

endmodule

// ===== verif/tb_key_event_report_aggregator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_event_report_aggregator: stimulus and verdict for the aggregator
// Directed key events and ticks cover every key value, unmatched and
// duplicate codes, disarmed ticks and the report limit; then random phases
// with different key codes and limits mix press/release bursts, long holds
// and noise. Both channels idle at random. A checker beside the block
// predicts and compares every record.
// ----------------------------------------------------------------------------
module tb_key_event_report_aggregator;
	import kera_pkg::*;

	localparam logic [VALUE_W-1:0]   KEY_PRESS      = 2'd1;
	localparam logic [VALUE_W-1:0]   KEY_REPEAT     = 2'd2;
	localparam logic [VALUE_W-1:0]   KEY_ODD        = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI  = 3'd7;
	localparam logic [CFG_IDX_W-1:0] KEY_REGS [KEY_SLOTS] =
		'{REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D, REG_KEY_E};
	localparam int SETTLE_CYCLES = 32;
	localparam int NUM_PHASES    = 6;
	localparam int PHASE_ITEMS   = 40;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int due_count;

	// Settings currently loaded, used to aim key events
	key_code_arr_t     codes_now;
	logic [MAXR_W-1:0] maxr_now;

	int ready_left = 0;
	logic ready_next;
	int ready_pick;

	kera_item_if item ();
	kera_rec_if  rec ();

	key_event_report_aggregator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.rec       (rec)
	);

	kera_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item        (item),
		.rec         (rec),
		.errors      (fail_count),
		.outstanding (due_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Record back-pressure: ready runs, short stalls, a few long ones
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 50) begin
				ready_next = 1'b1;
				ready_left = $urandom_range(1, 20);
			end else if (ready_pick < 85) begin
				ready_next = 1'b0;
				ready_left = $urandom_range(1, 3);
			end else if (ready_pick < 96) begin
				ready_next = 1'b0;
				ready_left = $urandom_range(4, 8);
			end else begin
				ready_next = 1'b0;
				ready_left = $urandom_range(15, 40);
			end
		end
		ready_left = ready_left - 1;
		rec.ready <= ready_next;
	end

	// One transaction on the item channel after a random gap; valid stays
	// high when the next one follows back to back
	task automatic send_item(input logic m, input logic [CODE_W-1:0] c,
		input logic [VALUE_W-1:0] v);
		int pick;
		int gap;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			gap = 0;
		else if (pick < 85)
			gap = $urandom_range(1, 3);
		else if (pick < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 40);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid     <= 1'b1;
		item.mode      <= m;
		item.key_code  <= c;
		item.key_value <= v;
		do @(posedge clk); while (!item.ready);
	endtask

	// Mostly a tracked code, sometimes anything
	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(0, 9) == 0)
			return CODE_W'($urandom_range(0, 65535));
		return codes_now[$urandom_range(0, KEY_SLOTS - 1)];
	endfunction

	// Wait for every record, then for the queue to drain of silent items
	task automatic settle();
		item.valid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	// Load codes_now and maxr_now; upper data bits of the limit are junk
	task automatic apply_setting();
		for (int i = 0; i < KEY_SLOTS; i++)
			cfg_write(KEY_REGS[i], codes_now[i]);
		cfg_write(REG_MAX_REPORTS, {8'($urandom_range(0, 255)), maxr_now});
		cfg_write(($urandom_range(0, 1) != 0) ? REG_UNUSED_LO : REG_UNUSED_HI,
			CFG_DATA_W'($urandom_range(0, 65535)));
		cfg_we <= 1'b0;
	endtask

	initial begin
		int budget;
		int pick;
		int n;
		int span;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		item.valid     = 1'b0;
		item.mode      = MODE_EVENT;
		item.key_code  = '0;
		item.key_value = VALUE_RELEASE;
		rec.ready      = 1'b0;
		codes_now      = KEY_CODE_RESET;
		maxr_now       = MAX_REPORTS_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Disarmed tick, unmatched event that must not arm, disarmed tick
		send_item(MODE_TICK, 16'h1234, KEY_PRESS);
		send_item(MODE_EVENT, 16'hffff, KEY_PRESS);
		send_item(MODE_TICK, 16'h0000, VALUE_RELEASE);
		// Every tracked key, with every key value among them, then reports and holds
		send_item(MODE_EVENT, codes_now[0], KEY_PRESS);
		send_item(MODE_EVENT, codes_now[1], VALUE_RELEASE);
		send_item(MODE_EVENT, codes_now[2], KEY_REPEAT);
		send_item(MODE_EVENT, codes_now[3], KEY_ODD);
		send_item(MODE_EVENT, codes_now[4], KEY_PRESS);
		send_item(MODE_TICK, 16'hffff, KEY_ODD);
		send_item(MODE_TICK, 16'h0000, VALUE_RELEASE);
		send_item(MODE_EVENT, codes_now[0], VALUE_RELEASE);
		send_item(MODE_TICK, 16'h5a5a, KEY_PRESS);
		send_item(MODE_TICK, 16'ha5a5, KEY_REPEAT);

		// Extreme and duplicate codes, report limit of zero
		settle();
		codes_now[0] = 16'h0000;
		codes_now[1] = 16'hffff;
		codes_now[2] = 16'h0000;
		codes_now[3] = 16'h5555;
		codes_now[4] = 16'haaaa;
		maxr_now     = 8'd0;
		apply_setting();
		send_item(MODE_EVENT, 16'h0000, KEY_PRESS);
		send_item(MODE_EVENT, 16'hffff, VALUE_RELEASE);
		send_item(MODE_EVENT, 16'h5555, KEY_ODD);
		send_item(MODE_EVENT, 16'haaaa, KEY_REPEAT);
		send_item(MODE_TICK, 16'h0000, VALUE_RELEASE);
		send_item(MODE_TICK, 16'hffff, KEY_ODD);
		// release only: session ends on the first report
		send_item(MODE_EVENT, 16'hffff, VALUE_RELEASE);
		send_item(MODE_TICK, 16'h0f0f, KEY_PRESS);

		// Random phases, each under its own setting
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			if (phase == 0) begin
				codes_now = KEY_CODE_RESET;
				maxr_now  = 8'd255;
			end else begin
				for (int i = 0; i < KEY_SLOTS; i++) begin
					if (i > 0 && $urandom_range(0, 3) == 0)
						codes_now[i] = codes_now[$urandom_range(0, i - 1)];
					else
						codes_now[i] = CODE_W'($urandom_range(0, 65535));
				end
				if (phase == 1)
					maxr_now = 8'd0;
				else if ($urandom_range(0, 3) == 0)
					maxr_now = MAXR_W'($urandom_range(0, 255));
				else
					maxr_now = MAXR_W'($urandom_range(1, 6));
			end
			apply_setting();

			budget = PHASE_ITEMS;
			while (budget > 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					// burst of events, then a few ticks
					n = $urandom_range(1, 6);
					repeat (n) send_item(MODE_EVENT, pick_code(),
						VALUE_W'($urandom_range(0, 3)));
					budget -= n;
					n = $urandom_range(1, 3);
					repeat (n) send_item(MODE_TICK, CODE_W'($urandom_range(0, 65535)),
						VALUE_W'($urandom_range(0, 3)));
					budget -= n;
				end else if (pick < 80) begin
					// held keys: presses, then ticks up to and past the limit
					n = $urandom_range(1, 2);
					repeat (n) send_item(MODE_EVENT, pick_code(),
						VALUE_W'($urandom_range(1, 3)));
					budget -= n;
					span = (maxr_now < 8'd10) ? int'(maxr_now) + 2 : 10;
					n = $urandom_range(1, span);
					repeat (n) send_item(MODE_TICK, CODE_W'($urandom_range(0, 65535)),
						VALUE_W'($urandom_range(0, 3)));
					budget -= n;
				end else begin
					// noise, mostly unmatched
					send_item(1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 65535)),
						VALUE_W'($urandom_range(0, 3)));
					budget -= 1;
				end
			end
		end

		settle();
		if (fail_count == 0 && due_count == 0) begin
			$display("key_event_report_aggregator test passed");
		end else begin
			$display("key_event_report_aggregator test failed");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#5_000_000;
		$display("key_event_report_aggregator test failed");
		$finish;
	end

endmodule
